[rtl/core/rational_lens_distortion_project_macros.svh]
// Assertion macros shared by the lens distortion RTL.
`ifndef RATIONAL_LENS_DISTORTION_PROJECT_MACROS_SVH
`define RATIONAL_LENS_DISTORTION_PROJECT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define RLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rld_pkg.sv]
// Types, constants and saturation helpers for the lens distortion pipeline.
package rld_pkg;

    localparam int IW      = 42;          // internal signed value width
    localparam int Q24_SH  = 24;
    localparam int QB      = 39;          // quotient magnitude bits
    localparam int MUL_LAT = 2;
    localparam int DIV_LAT = QB + 2;
    localparam int CFG_IW  = 8;

    localparam logic signed [IW-1:0]   LIM     = 42'sd549755813887;
    localparam logic signed [IW-1:0]   ONE_Q24 = 42'sd16777216;
    localparam logic signed [IW+1:0]   LIM_W   = (IW+2)'(LIM);
    localparam logic signed [IW+1:0]   S32_MAX = 44'sd2147483647;
    localparam logic signed [IW+1:0]   S32_MIN = -44'sd2147483648;

    typedef enum logic [CFG_IW-1:0] {
        CFG_PRINCIPAL = 8'd0,
        CFG_FOCAL     = 8'd1,
        CFG_NUMER_C0  = 8'd2,
        CFG_NUMER_C1  = 8'd3,
        CFG_NUMER_C2  = 8'd4,
        CFG_DENOM_C1  = 8'd5,
        CFG_DENOM_C2  = 8'd6,
        CFG_CENTRE    = 8'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } point_t;

    typedef struct packed {
        logic signed [31:0] pixel_u;
        logic signed [31:0] pixel_v;
        logic signed [31:0] jac_uu;
        logic signed [31:0] jac_uv;
        logic signed [31:0] jac_vu;
        logic signed [31:0] jac_vv;
        logic               range_error;
    } pixel_t;

    typedef struct packed {
        logic signed [IW-1:0] val;
        logic                 err;
    } sat_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               err;
    } sat32_t;

    function automatic sat_t sat_lim(input logic signed [IW+1:0] x);
        sat_t s;
        if (x > LIM_W) begin
            s.val = LIM;
            s.err = 1'b1;
        end else if (x < -LIM_W) begin
            s.val = -LIM;
            s.err = 1'b1;
        end else begin
            s.val = x[IW-1:0];
            s.err = 1'b0;
        end
        return s;
    endfunction

    function automatic sat_t add_sat(input logic signed [IW-1:0] a,
                                     input logic signed [IW-1:0] b);
        return sat_lim((IW+2)'(a) + (IW+2)'(b));
    endfunction

    function automatic sat32_t sat32(input logic signed [IW+1:0] x);
        sat32_t s;
        if (x > S32_MAX) begin
            s.val = S32_MAX[31:0];
            s.err = 1'b1;
        end else if (x < S32_MIN) begin
            s.val = S32_MIN[31:0];
            s.err = 1'b1;
        end else begin
            s.val = x[31:0];
            s.err = 1'b0;
        end
        return s;
    endfunction

endpackage

[rtl/core/rld_dly.sv]
// Enabled delay line that keeps side data aligned with the arithmetic stages.
module rld_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] sr_reg [0:N-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign q = sr_reg[N-1];
endmodule

[rtl/core/rld_mul.sv]
// Two-stage signed multiply, shift right with truncation toward zero, saturate.
module rld_mul #(
    parameter int SH = 16
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [rld_pkg::IW-1:0] a,
    input  logic signed [rld_pkg::IW-1:0] b,
    output logic signed [rld_pkg::IW-1:0] p,
    output logic                         err
);
    import rld_pkg::*;

    localparam int MW = IW - 1;
    localparam int LW = 32;
    localparam int HW = MW - LW;
    localparam int PW = 2 * MW;
    localparam logic [PW-1:0] LIM_P = PW'(LIM);

    logic [IW-1:0]        na;
    logic [IW-1:0]        nb;
    logic [MW-1:0]        ua;
    logic [MW-1:0]        ub;
    logic [2*LW-1:0]      pll_reg;
    logic [LW+HW-1:0]     plh_reg;
    logic [LW+HW-1:0]     phl_reg;
    logic [2*HW-1:0]      phh_reg;
    logic                 neg_reg;
    logic [PW-1:0]        prod;
    logic [PW-1:0]        quo;
    logic signed [IW-1:0] mag;
    logic signed [IW-1:0] p_next;
    logic                 err_next;
    logic signed [IW-1:0] p_reg;
    logic                 err_reg;

    always_comb
    begin
        na = a[IW-1] ? IW'(-a) : IW'(a);
        nb = b[IW-1] ? IW'(-b) : IW'(b);
        ua = na[MW-1:0];
        ub = nb[MW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pll_reg <= (2*LW)'(ua[LW-1:0]) * (2*LW)'(ub[LW-1:0]);
            plh_reg <= (LW+HW)'(ua[LW-1:0]) * (LW+HW)'(ub[MW-1:LW]);
            phl_reg <= (LW+HW)'(ua[MW-1:LW]) * (LW+HW)'(ub[LW-1:0]);
            phh_reg <= (2*HW)'(ua[MW-1:LW]) * (2*HW)'(ub[MW-1:LW]);
            neg_reg <= a[IW-1] ^ b[IW-1];
        end
    end

    always_comb
    begin
        prod = PW'(pll_reg) + (PW'(plh_reg) << LW) + (PW'(phl_reg) << LW)
             + (PW'(phh_reg) << (2*LW));
        quo  = prod >> SH;
        if (quo > LIM_P)
        begin
            mag      = LIM;
            err_next = 1'b1;
        end
        else
        begin
            mag      = quo[IW-1:0];
            err_next = 1'b0;
        end
        p_next = neg_reg ? -mag : mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg   <= p_next;
            err_reg <= err_next;
        end
    end

    assign p   = p_reg;
    assign err = err_reg;
endmodule

[rtl/core/rld_div.sv]
// Pipelined restoring divider: trunc((n * 2^24) / d), one quotient bit per stage.
module rld_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [rld_pkg::IW-1:0] n,
    input  logic signed [rld_pkg::IW-1:0] d,
    output logic signed [rld_pkg::IW-1:0] q,
    output logic                         ovf
);
    import rld_pkg::*;

    localparam int NW = QB + Q24_SH;
    localparam int XW = 2 * QB + 1;

    logic [IW-1:0]        an;
    logic [IW-1:0]        ad;
    logic [NW-1:0]        rem_reg [0:QB];
    logic [QB-1:0]        dv_reg  [0:QB];
    logic [QB-1:0]        quo_reg [0:QB];
    logic                 neg_reg [0:QB];
    logic                 ovf_reg [0:QB];
    logic signed [IW-1:0] qm;
    logic signed [IW-1:0] q_next;
    logic signed [IW-1:0] q_reg;
    logic                 ovf_out_reg;

    always_comb
    begin
        an = n[IW-1] ? IW'(-n) : IW'(n);
        ad = d[IW-1] ? IW'(-d) : IW'(d);
    end

    // The quotient only fits when the dividend is below the divisor times 2^QB.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {an[QB-1:0], {Q24_SH{1'b0}}};
            dv_reg[0]  <= ad[QB-1:0];
            quo_reg[0] <= '0;
            neg_reg[0] <= n[IW-1] ^ d[IW-1];
            ovf_reg[0] <= XW'({an[QB-1:0], {Q24_SH{1'b0}}}) >= (XW'(ad[QB-1:0]) << QB);
        end
    end

    for (genvar i = 1; i <= QB; i++)
    begin : g_step
        logic [XW-1:0] sub;
        logic          ge;

        always_comb
        begin
            sub = XW'(dv_reg[i-1]) << (QB - i);
            ge  = XW'(rem_reg[i-1]) >= sub;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? NW'(XW'(rem_reg[i-1]) - sub) : rem_reg[i-1];
                dv_reg[i]  <= dv_reg[i-1];
                quo_reg[i] <= {quo_reg[i-1][QB-2:0], ge};
                neg_reg[i] <= neg_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
    end

    always_comb
    begin
        qm     = ovf_reg[QB] ? LIM : IW'(quo_reg[QB]);
        q_next = neg_reg[QB] ? -qm : qm;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg       <= q_next;
            ovf_out_reg <= ovf_reg[QB];
        end
    end

    assign q   = q_reg;
    assign ovf = ovf_out_reg;
endmodule

[rtl/core/rational_lens_distortion_project.sv]
// Rational polynomial lens distortion projection with Jacobian, fully pipelined.
//
//  channel  | handshake               | beat contents
//  ---------+-------------------------+-----------------------------------------
//  point    | point_valid/point_ready | point_x, point_y (Q16.16)
//  pixel    | pixel_valid/pixel_ready | pixel u/v, 2x2 Jacobian, range_error
//  cfg      | cfg_valid/cfg_ready     | cfg_index, cfg_data (64 bit)
//
// One beat enters per clock while the output is not stalled; each passes 102 register stages
// to the output register, a depth set by the two bit-per-stage dividers and the multipliers.
// Reset clears the valid bits and loads the configuration registers with defaults.
// When an output beat waits, the whole pipeline holds and point_ready drops.
// cfg_ready is always high; writes take effect on the next clock.
`include "rational_lens_distortion_project_macros.svh"

module rational_lens_distortion_project (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       point_valid,
    output logic                       point_ready,
    input  rld_pkg::point_t            point,
    output logic                       pixel_valid,
    input  logic                       pixel_ready,
    output rld_pkg::pixel_t            pixel,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rld_pkg::CFG_IW-1:0] cfg_index,
    input  logic [63:0]                cfg_data
);
    import rld_pkg::*;

    localparam int SJ = 8 + DIV_LAT;
    localparam int SK = SJ + 3 + DIV_LAT;
    localparam int NV = SK + 9;

    // Configuration registers.
    logic [63:0] pp_reg;
    logic [63:0] fl_reg;
    logic [63:0] dc_reg;
    logic [31:0] nc0_reg;
    logic [31:0] nc1_reg;
    logic [31:0] nc2_reg;
    logic [31:0] dc1_reg;
    logic [31:0] dc2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_reg  <= 64'h0000800000008000;
            fl_reg  <= 64'h0001000000010000;
            dc_reg  <= '0;
            nc0_reg <= 32'h01000000;
            nc1_reg <= '0;
            nc2_reg <= '0;
            dc1_reg <= '0;
            dc2_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PRINCIPAL: pp_reg  <= cfg_data;
                CFG_FOCAL:     fl_reg  <= cfg_data;
                CFG_NUMER_C0:  nc0_reg <= cfg_data[31:0];
                CFG_NUMER_C1:  nc1_reg <= cfg_data[31:0];
                CFG_NUMER_C2:  nc2_reg <= cfg_data[31:0];
                CFG_DENOM_C1:  dc1_reg <= cfg_data[31:0];
                CFG_DENOM_C2:  dc2_reg <= cfg_data[31:0];
                CFG_CENTRE:    dc_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic signed [31:0] u0, v0, fx, fy, cx, cy;
    logic signed [IW-1:0] p0w, p1w, p2w, q1w, q2w, fxw, fyw, cxw, cyw;

    always_comb
    begin
        u0  = pp_reg[63:32];
        v0  = pp_reg[31:0];
        fx  = fl_reg[63:32];
        fy  = fl_reg[31:0];
        cx  = dc_reg[63:32];
        cy  = dc_reg[31:0];
        p0w = IW'(signed'(nc0_reg));
        p1w = IW'(signed'(nc1_reg));
        p2w = IW'(signed'(nc2_reg));
        q1w = IW'(signed'(dc1_reg));
        q2w = IW'(signed'(dc2_reg));
        fxw = IW'(fx);
        fyw = IW'(fy);
        cxw = IW'(cx);
        cyw = IW'(cy);
    end

    // Flow control: every stage advances together unless the output beat waits.
    logic pipe_en;
    logic vld_reg [0:NV-1];

    assign pipe_en     = !pixel_valid || pixel_ready;
    assign point_ready = pipe_en;
    assign pixel_valid = vld_reg[NV-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NV; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (pipe_en)
        begin
            vld_reg[0] <= point_valid;
            for (int i = 1; i < NV; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Offset from the distortion centre, then squared radius.
    logic signed [32:0] dx_reg, dy_reg;
    logic [32:0]        adx, ady;
    logic [65:0]        sqx_reg, sqy_reg;
    logic [50:0]        rsum;
    logic signed [IW-1:0] r_reg;
    logic               e2_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            dx_reg  <= 33'(point.point_x) - 33'(cx);
            dy_reg  <= 33'(point.point_y) - 33'(cy);
            sqx_reg <= 66'(adx) * 66'(adx);
            sqy_reg <= 66'(ady) * 66'(ady);
            r_reg   <= (rsum > 51'(LIM)) ? LIM : IW'(rsum);
            e2_reg  <= rsum > 51'(LIM);
        end
    end

    always_comb
    begin
        adx  = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        ady  = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        rsum = 51'(sqx_reg >> 16) + 51'(sqy_reg >> 16);
    end

    // Inner Horner step of both polynomials, plus the inner terms of their derivatives.
    logic signed [IW-1:0] tp, tq;
    logic                 tp_err, tq_err, e2d;
    logic [IW-1:0]        r5_raw;
    logic signed [IW-1:0] r5;

    rld_mul #(.SH(16)) u_tp (.clk(clk), .en(pipe_en), .a(r_reg), .b(p2w), .p(tp), .err(tp_err));
    rld_mul #(.SH(16)) u_tq (.clk(clk), .en(pipe_en), .a(r_reg), .b(q2w), .p(tq), .err(tq_err));
    rld_dly #(.W(IW), .N(3))      u_r5  (.clk(clk), .en(pipe_en), .d(r_reg), .q(r5_raw));
    rld_dly #(.W(1), .N(MUL_LAT)) u_e2d (.clk(clk), .en(pipe_en), .d(e2_reg), .q(e2d));
    assign r5 = signed'(r5_raw);

    sat_t ap_s, aq_s, dn_s, dd_s;
    logic signed [IW-1:0] ap_reg, aq_reg, dnum_reg, dden_reg;
    logic                 e5_reg;

    always_comb
    begin
        ap_s = add_sat(p1w, tp);
        aq_s = add_sat(q1w, tq);
        dn_s = add_sat(p1w, tp <<< 1);
        dd_s = add_sat(q1w, tq <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            ap_reg   <= ap_s.val;
            aq_reg   <= aq_s.val;
            dnum_reg <= dn_s.val;
            dden_reg <= dd_s.val;
            e5_reg   <= e2d | tp_err | tq_err | ap_s.err | aq_s.err | dn_s.err | dd_s.err;
        end
    end

    // Outer Horner step gives numerator and denominator.
    logic signed [IW-1:0] mp, mq;
    logic                 mp_err, mq_err, e5d;

    rld_mul #(.SH(16)) u_mp (.clk(clk), .en(pipe_en), .a(r5), .b(ap_reg), .p(mp), .err(mp_err));
    rld_mul #(.SH(16)) u_mq (.clk(clk), .en(pipe_en), .a(r5), .b(aq_reg), .p(mq), .err(mq_err));
    rld_dly #(.W(1), .N(MUL_LAT)) u_e5d (.clk(clk), .en(pipe_en), .d(e5_reg), .q(e5d));

    sat_t num_s, den_s;
    logic signed [IW-1:0] num_reg, den_reg;
    logic                 e8_reg, dz8;

    always_comb
    begin
        num_s = add_sat(p0w, mp);
        den_s = add_sat(ONE_Q24, mq);
        dz8   = (den_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            num_reg <= num_s.val;
            den_reg <= den_s.val;
            e8_reg  <= e5d | mp_err | mq_err | num_s.err | den_s.err;
        end
    end

    // First division: the distortion factor D.
    logic signed [IW-1:0] dd_raw, ddj, ddenj, dnumj2, denj3;
    logic [IW-1:0]        ddenj_raw, dnumj2_raw, denj3_raw;
    logic                 ovf1, dzj, e8j, ej, ej2;

    rld_div u_div1 (.clk(clk), .en(pipe_en), .n(num_reg), .d(den_reg), .q(dd_raw), .ovf(ovf1));
    rld_dly #(.W(1), .N(DIV_LAT))     u_dzj  (.clk(clk), .en(pipe_en), .d(dz8), .q(dzj));
    rld_dly #(.W(1), .N(DIV_LAT))     u_e8j  (.clk(clk), .en(pipe_en), .d(e8_reg), .q(e8j));
    rld_dly #(.W(IW), .N(DIV_LAT+3))  u_ddnj (.clk(clk), .en(pipe_en), .d(dden_reg),
                                             .q(ddenj_raw));
    rld_dly #(.W(IW), .N(DIV_LAT+5))  u_dnj  (.clk(clk), .en(pipe_en), .d(dnum_reg),
                                             .q(dnumj2_raw));
    rld_dly #(.W(IW), .N(DIV_LAT+3))  u_denj (.clk(clk), .en(pipe_en), .d(den_reg),
                                             .q(denj3_raw));

    always_comb
    begin
        ddj    = dzj ? '0 : dd_raw;
        ej     = e8j | dzj | ovf1;
        ddenj  = signed'(ddenj_raw);
        dnumj2 = signed'(dnumj2_raw);
        denj3  = signed'(denj3_raw);
    end

    logic signed [IW-1:0] md;
    logic                 md_err;

    rld_mul #(.SH(24)) u_md (.clk(clk), .en(pipe_en), .a(ddj), .b(ddenj), .p(md), .err(md_err));
    rld_dly #(.W(1), .N(MUL_LAT)) u_ej2 (.clk(clk), .en(pipe_en), .d(ej), .q(ej2));

    sat_t diff_s;
    logic signed [IW-1:0] diff_reg;
    logic                 ej3_reg;

    always_comb
    begin
        diff_s = add_sat(dnumj2, -md);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            diff_reg <= diff_s.val;
            ej3_reg  <= ej2 | md_err | diff_s.err;
        end
    end

    // Second division: the derivative dD/dR.
    logic signed [IW-1:0] ddr_raw, ddrk, ddk, dxk, dyk, dxk2, dyk2, ddk4;
    logic [IW-1:0]        ddk_raw, ddk4_raw;
    logic [32:0]          dxk_raw, dyk_raw, dxk2_raw, dyk2_raw;
    logic                 ovf2, dzk, ekp, ek;

    rld_div u_div2 (.clk(clk), .en(pipe_en), .n(diff_reg), .d(denj3), .q(ddr_raw), .ovf(ovf2));
    rld_dly #(.W(1), .N(DIV_LAT+3))  u_dzk (.clk(clk), .en(pipe_en), .d(dzj), .q(dzk));
    rld_dly #(.W(1), .N(DIV_LAT))    u_ekp (.clk(clk), .en(pipe_en), .d(ej3_reg), .q(ekp));
    rld_dly #(.W(IW), .N(DIV_LAT+3)) u_ddk (.clk(clk), .en(pipe_en), .d(ddj), .q(ddk_raw));
    rld_dly #(.W(IW), .N(4))         u_dd4 (.clk(clk), .en(pipe_en), .d(ddk_raw), .q(ddk4_raw));
    rld_dly #(.W(33), .N(SK))        u_dxk (.clk(clk), .en(pipe_en), .d(dx_reg), .q(dxk_raw));
    rld_dly #(.W(33), .N(SK))        u_dyk (.clk(clk), .en(pipe_en), .d(dy_reg), .q(dyk_raw));
    rld_dly #(.W(33), .N(MUL_LAT))   u_dx2 (.clk(clk), .en(pipe_en), .d(dxk_raw), .q(dxk2_raw));
    rld_dly #(.W(33), .N(MUL_LAT))   u_dy2 (.clk(clk), .en(pipe_en), .d(dyk_raw), .q(dyk2_raw));

    always_comb
    begin
        ddrk = dzk ? '0 : ddr_raw;
        ek   = ekp | ovf2;
        ddk  = signed'(ddk_raw);
        ddk4 = signed'(ddk4_raw);
        dxk  = IW'(signed'(dxk_raw));
        dyk  = IW'(signed'(dyk_raw));
        dxk2 = IW'(signed'(dxk2_raw));
        dyk2 = IW'(signed'(dyk2_raw));
    end

    // Scaled offsets and gradient terms.
    logic signed [IW-1:0] exm, eym, gx, gy;
    logic                 exm_err, eym_err, gx_err, gy_err, ek2, ek2w;

    rld_mul #(.SH(24)) u_exm (.clk(clk), .en(pipe_en), .a(ddk), .b(dxk), .p(exm), .err(exm_err));
    rld_mul #(.SH(24)) u_eym (.clk(clk), .en(pipe_en), .a(ddk), .b(dyk), .p(eym), .err(eym_err));
    rld_mul #(.SH(16)) u_gx  (.clk(clk), .en(pipe_en), .a(dxk), .b(ddrk), .p(gx), .err(gx_err));
    rld_mul #(.SH(16)) u_gy  (.clk(clk), .en(pipe_en), .a(dyk), .b(ddrk), .p(gy), .err(gy_err));
    rld_dly #(.W(1), .N(MUL_LAT)) u_ek2 (.clk(clk), .en(pipe_en), .d(ek), .q(ek2));

    assign ek2w = ek2 | exm_err | eym_err | gx_err | gy_err;

    sat_t ex_s, ey_s;
    logic signed [IW-1:0] ex_reg, ey_reg;
    logic                 ek3_reg;

    always_comb
    begin
        ex_s = add_sat(exm, cxw);
        ey_s = add_sat(eym, cyw);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            ex_reg  <= ex_s.val;
            ey_reg  <= ey_s.val;
            ek3_reg <= ek2w | ex_s.err | ey_s.err;
        end
    end

    // dR/dx and dR/dy are twice the centre offsets.
    logic signed [IW-1:0] gxx, gxy, gyx, gyy;
    logic                 gxx_err, gxy_err, gyx_err, gyy_err, ek4, ek4w;

    rld_mul #(.SH(16)) u_gxx (.clk(clk), .en(pipe_en), .a(gx), .b(dxk2 <<< 1), .p(gxx),
                              .err(gxx_err));
    rld_mul #(.SH(16)) u_gxy (.clk(clk), .en(pipe_en), .a(gx), .b(dyk2 <<< 1), .p(gxy),
                              .err(gxy_err));
    rld_mul #(.SH(16)) u_gyx (.clk(clk), .en(pipe_en), .a(gy), .b(dxk2 <<< 1), .p(gyx),
                              .err(gyx_err));
    rld_mul #(.SH(16)) u_gyy (.clk(clk), .en(pipe_en), .a(gy), .b(dyk2 <<< 1), .p(gyy),
                              .err(gyy_err));
    rld_dly #(.W(1), .N(1)) u_ek4 (.clk(clk), .en(pipe_en), .d(ek3_reg), .q(ek4));

    assign ek4w = ek4 | gxx_err | gxy_err | gyx_err | gyy_err;

    logic signed [IW-1:0] pum, pvm;
    logic                 pum_err, pvm_err;

    rld_mul #(.SH(16)) u_pum (.clk(clk), .en(pipe_en), .a(fxw), .b(ex_reg), .p(pum),
                              .err(pum_err));
    rld_mul #(.SH(16)) u_pvm (.clk(clk), .en(pipe_en), .a(fyw), .b(ey_reg), .p(pvm),
                              .err(pvm_err));

    sat_t juu_s, jvv_s;
    logic signed [IW-1:0] juu_in_reg, jvv_in_reg, juv_in_reg, jvu_in_reg;
    logic                 ek5_reg;

    always_comb
    begin
        juu_s = add_sat(ddk4, gxx);
        jvv_s = add_sat(ddk4, gyy);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            juu_in_reg <= juu_s.val;
            jvv_in_reg <= jvv_s.val;
            juv_in_reg <= gxy;
            jvu_in_reg <= gyx;
            ek5_reg    <= ek4w | juu_s.err | jvv_s.err;
        end
    end

    // Focal scaling of the Jacobian; pixel products wait alongside.
    logic signed [IW-1:0] juu, juv, jvu, jvv, pu7, pv7;
    logic [IW-1:0]        pu7_raw, pv7_raw;
    logic                 juu_err, juv_err, jvu_err, jvv_err, ek7, pe7;

    rld_mul #(.SH(24)) u_juu (.clk(clk), .en(pipe_en), .a(fxw), .b(juu_in_reg), .p(juu),
                              .err(juu_err));
    rld_mul #(.SH(24)) u_juv (.clk(clk), .en(pipe_en), .a(fxw), .b(juv_in_reg), .p(juv),
                              .err(juv_err));
    rld_mul #(.SH(24)) u_jvu (.clk(clk), .en(pipe_en), .a(fyw), .b(jvu_in_reg), .p(jvu),
                              .err(jvu_err));
    rld_mul #(.SH(24)) u_jvv (.clk(clk), .en(pipe_en), .a(fyw), .b(jvv_in_reg), .p(jvv),
                              .err(jvv_err));
    rld_dly #(.W(1), .N(MUL_LAT))  u_ek7 (.clk(clk), .en(pipe_en), .d(ek5_reg), .q(ek7));
    rld_dly #(.W(1), .N(MUL_LAT))  u_pe7 (.clk(clk), .en(pipe_en), .d(pum_err | pvm_err),
                                          .q(pe7));
    rld_dly #(.W(IW), .N(MUL_LAT)) u_pu7 (.clk(clk), .en(pipe_en), .d(pum), .q(pu7_raw));
    rld_dly #(.W(IW), .N(MUL_LAT)) u_pv7 (.clk(clk), .en(pipe_en), .d(pvm), .q(pv7_raw));

    assign pu7 = signed'(pu7_raw);
    assign pv7 = signed'(pv7_raw);

    // Output register.
    sat32_t ou, ov, ouu, ouv, ovu, ovv;
    pixel_t pix_next;
    pixel_t pix_reg;

    always_comb
    begin
        ou  = sat32((IW+2)'(pu7) + (IW+2)'(u0));
        ov  = sat32((IW+2)'(pv7) + (IW+2)'(v0));
        ouu = sat32((IW+2)'(juu));
        ouv = sat32((IW+2)'(juv));
        ovu = sat32((IW+2)'(jvu));
        ovv = sat32((IW+2)'(jvv));
        pix_next.pixel_u     = ou.val;
        pix_next.pixel_v     = ov.val;
        pix_next.jac_uu      = ouu.val;
        pix_next.jac_uv      = ouv.val;
        pix_next.jac_vu      = ovu.val;
        pix_next.jac_vv      = ovv.val;
        pix_next.range_error = ek7 | pe7 | juu_err | juv_err | jvu_err | jvv_err
                             | ou.err | ov.err | ouu.err | ouv.err | ovu.err | ovv.err;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pixel = pix_reg;

    `RLD_ASSERT_NOW(a_stall_blocks_input, pixel_valid && !pixel_ready, !point_ready,
                    "input accepted while the output beat is stalled")
    `RLD_ASSERT_NEXT(a_accept_enters, point_valid && point_ready, vld_reg[0],
                     "accepted beat did not enter the first stage")
    `RLD_ASSERT_NEXT(a_last_reaches_out, vld_reg[NV-2] && pipe_en, pixel_valid,
                     "beat in the last stage did not reach the output")
endmodule
